// ----- rtl/core/mono_lcd_frame_buffer_glyph_refresh_unit_defines.svh -----
// Assertion macros for the monochrome LCD frame buffer block.
// Used by the top level only; needs clk_i and rst_ni in scope.
`ifndef MONO_LCD_FRAME_BUFFER_GLYPH_REFRESH_UNIT_DEFINES_SVH
`define MONO_LCD_FRAME_BUFFER_GLYPH_REFRESH_UNIT_DEFINES_SVH

// Checked at every rising edge outside reset.
`define MLCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define MLCD_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/mlcd_pkg.sv -----
// Shared types, constants and helper functions of the LCD frame buffer block.
// No dependencies; imported by every module of the block.
package mlcd_pkg;

  localparam int WIDTH_PIXELS = 128;
  localparam int HEIGHT_ROWS  = 64;
  localparam int ROW_BYTES    = (WIDTH_PIXELS + 7) / 8;
  localparam int STORE_BYTES  = ROW_BYTES * HEIGHT_ROWS;
  localparam int ADDR_W       = $clog2(STORE_BYTES);
  localparam int COL_W        = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int ROW_W        = $clog2(HEIGHT_ROWS);

  localparam int GLYPH_W      = 6;
  localparam int GLYPH_H      = 8;
  localparam int SPLIT_ROW    = 32;
  localparam int HIGH_H_BASE  = 8;

  localparam int CFG_IDX_W    = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ROW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_BASE = 1'b1;

  localparam logic [7:0] TEXT_ROW_RESET  = 8'd1;
  localparam logic [7:0] ADDR_BASE_RESET = 8'd128;
  localparam logic [7:0] CURSOR_RESET    = 8'd1;

  typedef enum logic [2:0] {
    CMD_CLEAR     = 3'd0,
    CMD_PATTERN   = 3'd1,
    CMD_GLYPH_AT  = 3'd2,
    CMD_GLYPH_CUR = 3'd3,
    CMD_REFRESH   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [47:0] glyph;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [5:0]  refresh_row;
  } in_item_t;

  typedef struct packed {
    logic       write_is_data;
    logic [7:0] write_byte;
    logic       last_of_run;
  } out_item_t;

  // One command as handed from the top level to the sequencer, with the
  // glyph origin already resolved.
  typedef struct packed {
    logic [2:0]  command;
    logic [47:0] glyph;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [5:0]  row;
  } job_t;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
    addr_of = ADDR_W'(row) * ADDR_W'(ROW_BYTES) + ADDR_W'(col);
  endfunction

  // Rewrites the pixels of one stored byte that fall inside the glyph box.
  // sel_hi picks the second byte that a glyph straddling a byte boundary
  // touches; x_lo is the glyph's left column within the first byte.
  function automatic logic [7:0] glyph_merge(input logic [7:0]  old_byte,
                                             input logic [47:0] glyph,
                                             input logic [2:0]  x_lo,
                                             input logic        sel_hi,
                                             input logic [2:0]  row);
    logic [7:0] res;
    logic [3:0] pos;
    logic [3:0] off;
    res = old_byte;
    for (int k = 0; k < 8; k++) begin
      pos = {sel_hi, 3'(k)};
      off = pos - {1'b0, x_lo};
      if (pos >= {1'b0, x_lo} && off < 4'(GLYPH_W)) begin
        res[7-k] = glyph[{off[2:0], row}];
      end
    end
    glyph_merge = res;
  endfunction

endpackage

// ----- rtl/core/mlcd_fb_ram.sv -----
// Single-port frame buffer memory, one byte per entry, registered read.
// Depends on mlcd_pkg for the depth and address width.
module mlcd_fb_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [mlcd_pkg::ADDR_W-1:0] addr_i,
  input  logic [7:0]                 wdata_i,
  output logic [7:0]                 rdata_o
);
  import mlcd_pkg::*;

  logic [7:0] mem_q [STORE_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/mlcd_seq.sv -----
// Command sequencer: sweeps, glyph read-modify-write and row refresh.
// Depends on mlcd_pkg and instantiates mlcd_fb_ram.
module mlcd_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  mlcd_pkg::job_t      job_i,
  input  logic [7:0]          base_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mlcd_pkg::out_item_t out_item_o
);
  import mlcd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_G_RD,
    S_G_WR,
    S_R_CMD0,
    S_R_CMD1,
    S_R_RD,
    S_R_LD
  } state_e;

  state_e           state_q, state_d;
  logic             fill_pat_q, fill_pat_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [2:0]       gr_q, gr_d;
  logic             gb_q, gb_d;
  logic             need2_q, need2_d;
  logic [2:0]       x_lo_q, x_lo_d;
  logic [47:0]      glyph_q, glyph_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;

  logic             mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]       mem_wdata;
  logic [7:0]       mem_rdata;
  logic             slot_free;
  logic             glyph_fits;
  logic [ROW_W-1:0] g_row;
  logic [COL_W-1:0] g_col;
  logic [7:0]       v_addr;
  logic [7:0]       h_addr;

  mlcd_fb_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign glyph_fits = ({1'b0, job_i.x} + 9'(GLYPH_W) <= 9'(WIDTH_PIXELS)) &&
                      ({1'b0, job_i.y} + 9'(GLYPH_H) <= 9'(HEIGHT_ROWS));
  assign g_row      = row_q + ROW_W'(gr_q);
  assign g_col      = col_q + COL_W'(gb_q);

  always_comb begin
    if (8'(row_q) < 8'(SPLIT_ROW)) begin
      v_addr = 8'(row_q);
      h_addr = 8'd0;
    end else begin
      v_addr = 8'(row_q) - 8'(SPLIT_ROW);
      h_addr = 8'(HIGH_H_BASE);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = addr_of(row_q, col_q);
    mem_wdata = 8'd0;
    case (state_q)
      S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = fill_pat_q ? (8'(col_q) + 8'(row_q >> 2) + 8'd1) : 8'd0;
      end
      S_G_RD: begin
        mem_addr = addr_of(g_row, g_col);
      end
      S_G_WR: begin
        mem_we    = 1'b1;
        mem_addr  = addr_of(g_row, g_col);
        mem_wdata = glyph_merge(mem_rdata, glyph_q, x_lo_q, gb_q, gr_q);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    fill_pat_d  = fill_pat_q;
    row_d       = row_q;
    col_d       = col_q;
    gr_d        = gr_q;
    gb_d        = gb_q;
    need2_d     = need2_q;
    x_lo_d      = x_lo_q;
    glyph_d     = glyph_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          glyph_d = job_i.glyph;
          case (job_i.command)
            CMD_CLEAR, CMD_PATTERN: begin
              fill_pat_d = (job_i.command == CMD_PATTERN);
              row_d      = '0;
              col_d      = '0;
              state_d    = S_FILL;
            end
            CMD_GLYPH_AT, CMD_GLYPH_CUR: begin
              row_d   = ROW_W'(job_i.y);
              col_d   = COL_W'(job_i.x >> 3);
              x_lo_d  = job_i.x[2:0];
              need2_d = (4'(job_i.x[2:0]) + 4'(GLYPH_W) > 4'd8);
              gr_d    = '0;
              gb_d    = 1'b0;
              if (glyph_fits) begin
                state_d = S_G_RD;
              end
            end
            CMD_REFRESH: begin
              row_d = ROW_W'(job_i.row);
              if ({1'b0, job_i.row} < 7'(HEIGHT_ROWS)) begin
                state_d = S_R_CMD0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FILL: begin
        if (col_q == COL_W'(ROW_BYTES - 1)) begin
          col_d = '0;
          row_d = row_q + 1'b1;
          if (row_q == ROW_W'(HEIGHT_ROWS - 1)) begin
            state_d = S_IDLE;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      S_G_RD: begin
        state_d = S_G_WR;
      end
      S_G_WR: begin
        if (!gb_q && need2_q) begin
          gb_d    = 1'b1;
          state_d = S_G_RD;
        end else begin
          gb_d = 1'b0;
          if (gr_q == 3'(GLYPH_H - 1)) begin
            state_d = S_IDLE;
          end else begin
            gr_d    = gr_q + 1'b1;
            state_d = S_G_RD;
          end
        end
      end
      S_R_CMD0: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_item_d  = '{write_is_data: 1'b0, write_byte: base_i | v_addr,
                          last_of_run: 1'b0};
          state_d     = S_R_CMD1;
        end
      end
      S_R_CMD1: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_item_d  = '{write_is_data: 1'b0, write_byte: base_i | h_addr,
                          last_of_run: 1'b0};
          col_d       = '0;
          state_d     = S_R_RD;
        end
      end
      S_R_RD: begin
        // Read only once the output slot is sure to be empty next cycle.
        if (slot_free) begin
          state_d = S_R_LD;
        end
      end
      S_R_LD: begin
        out_valid_d = 1'b1;
        out_item_d  = '{write_is_data: 1'b1, write_byte: mem_rdata,
                        last_of_run: (col_q == COL_W'(ROW_BYTES - 1))};
        if (col_q == COL_W'(ROW_BYTES - 1)) begin
          state_d = S_IDLE;
        end else begin
          col_d   = col_q + 1'b1;
          state_d = S_R_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Reset starts a clearing sweep of the whole store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      fill_pat_q  <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      gr_q        <= '0;
      gb_q        <= 1'b0;
      need2_q     <= 1'b0;
      x_lo_q      <= '0;
      glyph_q     <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      state_q     <= state_d;
      fill_pat_q  <= fill_pat_d;
      row_q       <= row_d;
      col_q       <= col_d;
      gr_q        <= gr_d;
      gb_q        <= gb_d;
      need2_q     <= need2_d;
      x_lo_q      <= x_lo_d;
      glyph_q     <= glyph_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  assign ready_o     = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- rtl/core/mono_lcd_frame_buffer_glyph_refresh_unit.sv -----
// Top level of the monochrome LCD frame buffer: configuration, text cursor.
// Depends on mlcd_pkg, the assertion header and mlcd_seq.
`include "mono_lcd_frame_buffer_glyph_refresh_unit_defines.svh"

// A 128x64 one-bit frame buffer held in a single-port 1024-byte memory, with
// commands to clear it, fill a test pattern, draw 6x8 glyphs at a position or
// at the text cursor, and send one row to the display controller. Commands
// are taken one at a time; the memory port, one byte per cycle, sets the
// cost. A clear or test pattern writes every byte of the store in turn. A
// glyph takes a read and a write-back for each byte touched, two bytes per
// row when it straddles a byte boundary; a glyph past the edge, like an
// unused command code, leaves the block idle at once. A refresh sends two
// address command beats, then for each data beat a memory read followed by
// the output load, and waits while the receiver stalls. After reset the
// store is cleared by a pass over all of it during which input is stalled;
// configuration writes are accepted at any time.
module mono_lcd_frame_buffer_glyph_refresh_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  mlcd_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output mlcd_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mlcd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [7:0]                      cfg_data_i
);
  import mlcd_pkg::*;

  logic [7:0] text_row_q, text_row_d;
  logic [7:0] addr_base_q, addr_base_d;
  logic [7:0] cursor_col_q, cursor_col_d;
  logic       seq_ready;
  logic       in_accept;
  job_t       job;

  assign in_stall_o  = !seq_ready;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    job.command = in_item_i.command;
    job.glyph   = in_item_i.glyph;
    job.row     = in_item_i.refresh_row;
    if (in_item_i.command == CMD_GLYPH_CUR) begin
      job.x = cursor_col_q;
      job.y = text_row_q;
    end else begin
      job.x = in_item_i.pos_x;
      job.y = in_item_i.pos_y;
    end
  end

  always_comb begin
    text_row_d   = text_row_q;
    addr_base_d  = addr_base_q;
    cursor_col_d = cursor_col_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TEXT_ROW:  text_row_d  = cfg_data_i;
        CFG_ADDR_BASE: addr_base_d = cfg_data_i;
        default: begin
        end
      endcase
    end
    // The cursor moves on even when the glyph is skipped at the edge.
    if (in_accept && in_item_i.command == CMD_GLYPH_CUR) begin
      cursor_col_d = cursor_col_q + 8'(GLYPH_W);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_row_q   <= TEXT_ROW_RESET;
      addr_base_q  <= ADDR_BASE_RESET;
      cursor_col_q <= CURSOR_RESET;
    end else begin
      text_row_q   <= text_row_d;
      addr_base_q  <= addr_base_d;
      cursor_col_q <= cursor_col_d;
    end
  end

  mlcd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .job_i       (job),
    .base_i      (addr_base_q),
    .ready_o     (seq_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  `MLCD_ASSERT(a_cursor_moves_on_cursor_glyph, !$stable(cursor_col_q) |-> $past(in_accept) && ($past(in_item_i.command) == CMD_GLYPH_CUR), "cursor moved without a cursor glyph beat")
  `MLCD_ASSERT(a_refresh_keeps_busy, in_accept && (in_item_i.command == CMD_REFRESH) && ({1'b0, in_item_i.refresh_row} < 7'(HEIGHT_ROWS)) |=> in_stall_o, "refresh accepted but block went idle")
  `MLCD_ASSERT_ANY(a_row_busy_until_last, out_valid_o && !out_stall_i && out_item_o.write_is_data && !out_item_o.last_of_run |=> in_stall_o, "input taken before the row was complete")

endmodule

// ----- sim/mlcd_write_checker.sv -----
// Checker for the LCD frame buffer block: keeps its own copy of the pixel
// store, cursor and registers, and compares every controller write beat.
// Depends on mlcd_pkg only; instantiated by tb_top beside the block.
module mlcd_write_checker
  import mlcd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_item_t             in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_item_t            out_item_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  output int                   pending_o,
  output int                   errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] pixels [STORE_BYTES];
  logic [7:0] cursor_col;
  logic [7:0] text_row;
  logic [7:0] addr_base;
  out_item_t  lcd_writes_due [$];
  int         mismatches = 0;

  function automatic out_item_t lcd_write(input logic is_data, input logic [7:0] value,
                                          input logic last);
    out_item_t w;
    w.write_is_data = is_data;
    w.write_byte    = value;
    w.last_of_run   = last;
    return w;
  endfunction

  // The whole 6x8 box is overwritten, or nothing at all if it would cross an edge.
  function automatic void draw_glyph(input logic [47:0] bits, input int x, input int y);
    int px;
    int idx;
    if (x + GLYPH_W > WIDTH_PIXELS || y + GLYPH_H > HEIGHT_ROWS) return;
    for (int r = 0; r < GLYPH_H; r++) begin
      for (int c = 0; c < GLYPH_W; c++) begin
        px  = x + c;
        idx = (y + r) * ROW_BYTES + px / 8;
        pixels[idx][7 - px % 8] = bits[c * 8 + r];
      end
    end
  endfunction

  function automatic void run_command(input in_item_t it);
    int         row;
    logic [7:0] v_addr;
    logic [7:0] h_addr;
    row = it.refresh_row;
    case (it.command)
      CMD_CLEAR: begin
        foreach (pixels[i]) pixels[i] = '0;
      end
      CMD_PATTERN: begin
        for (int r = 0; r < HEIGHT_ROWS; r++) begin
          for (int c = 0; c < ROW_BYTES; c++) begin
            pixels[r * ROW_BYTES + c] = 8'(c + r / 4 + 1);
          end
        end
      end
      CMD_GLYPH_AT: begin
        draw_glyph(it.glyph, it.pos_x, it.pos_y);
      end
      CMD_GLYPH_CUR: begin
        draw_glyph(it.glyph, cursor_col, text_row);
        cursor_col = cursor_col + 8'(GLYPH_W);
      end
      CMD_REFRESH: begin
        if (row < HEIGHT_ROWS) begin
          // The lower half of the panel sits behind horizontal base eight.
          v_addr = (row < SPLIT_ROW) ? 8'(row) : 8'(row - SPLIT_ROW);
          h_addr = (row < SPLIT_ROW) ? 8'd0 : 8'(HIGH_H_BASE);
          lcd_writes_due.push_back(lcd_write(1'b0, addr_base | v_addr, 1'b0));
          lcd_writes_due.push_back(lcd_write(1'b0, addr_base | h_addr, 1'b0));
          for (int c = 0; c < ROW_BYTES; c++) begin
            lcd_writes_due.push_back(lcd_write(1'b1, pixels[row * ROW_BYTES + c],
                                               c == ROW_BYTES - 1));
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      foreach (pixels[i]) pixels[i] = '0;
      cursor_col = CURSOR_RESET;
      text_row   = TEXT_ROW_RESET;
      addr_base  = ADDR_BASE_RESET;
      lcd_writes_due.delete();
      pending_o <= 0;
      errors_o  <= mismatches;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (lcd_writes_due.size() == 0) begin
          $error("unexpected write beat: write_is_data %0d write_byte 0x%02h last_of_run %0d",
                 out_item_i.write_is_data, out_item_i.write_byte, out_item_i.last_of_run);
          mismatches++;
        end else begin
          want = lcd_writes_due.pop_front();
          if (out_item_i.write_is_data !== want.write_is_data) begin
            $error("write_is_data: expected %0d, actual %0d",
                   want.write_is_data, out_item_i.write_is_data);
            mismatches++;
          end
          if (out_item_i.write_byte !== want.write_byte) begin
            $error("write_byte: expected 0x%02h, actual 0x%02h",
                   want.write_byte, out_item_i.write_byte);
            mismatches++;
          end
          if (out_item_i.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d",
                   want.last_of_run, out_item_i.last_of_run);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TEXT_ROW:  text_row  = cfg_data_i;
          CFG_ADDR_BASE: addr_base = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) run_command(in_item_i);
      pending_o <= lcd_writes_due.size();
      errors_o  <= mismatches;
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Top of the LCD frame buffer testbench: clock, reset, command and register
// stimulus, receiver back-pressure and the verdict. Depends on mlcd_pkg, the
// block itself and mlcd_write_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mlcd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // A clear or a test pattern sweeps the whole store and shows nothing outside.
  localparam int          SETTLE_CYCLES = 1100;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          PHASES        = 5;
  localparam int          RANDOM_ITEMS  = 6;
  localparam int          TEXT_GLYPHS   = 44;
  localparam logic [2:0]  CMD_SPARE_LO  = 3'(CMD_REFRESH + 1);
  localparam logic [2:0]  CMD_SPARE_HI  = 3'b111;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_item_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_item_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_TEXT_ROW;
  logic [7:0]           cfg_data_i  = '0;

  int pending;
  int fail_count;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int holds_asked   = 0;
  int holds_served  = 0;

  int         idle_by_phase  [PHASES] = '{0, 78, 0, 28, 0};
  int         stall_by_phase [PHASES] = '{0, 0, 78, 28, 0};
  logic [7:0] row_by_phase   [PHASES] = '{8'd0, 8'd255, 8'd56, 8'd0, 8'd0};
  logic [7:0] base_by_phase  [PHASES] = '{8'd0, 8'd255, 8'd128, 8'd0, 8'd0};

  mono_lcd_frame_buffer_glyph_refresh_unit dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  mlcd_write_checker u_monitor (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_item_i(out_item_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .errors_o(fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic in_item_t build(input logic [2:0] cmd, input logic [47:0] bits,
                                     input logic [7:0] x, input logic [7:0] y,
                                     input logic [5:0] row);
    in_item_t it;
    it.command     = cmd;
    it.glyph       = bits;
    it.pos_x       = x;
    it.pos_y       = y;
    it.refresh_row = row;
    return it;
  endfunction

  // Mostly boxes that fit, some hugging the edge, a few anywhere in range.
  function automatic logic [7:0] glyph_origin(input int last_fit);
    int p;
    p = $urandom_range(9, 0);
    if (p < 7) return 8'($urandom_range(last_fit, 0));
    if (p < 9) return 8'($urandom_range(last_fit + 3, last_fit - 2));
    return 8'($urandom_range(255, 0));
  endfunction

  function automatic in_item_t random_command();
    int         pick;
    logic [2:0] cmd;
    pick = $urandom_range(99, 0);
    if (pick < 4)       cmd = CMD_CLEAR;
    else if (pick < 9)  cmd = CMD_PATTERN;
    else if (pick < 39) cmd = CMD_GLYPH_AT;
    else if (pick < 54) cmd = CMD_GLYPH_CUR;
    else if (pick < 95) cmd = CMD_REFRESH;
    else                cmd = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
    return build(cmd, 48'({$urandom, $urandom}), glyph_origin(WIDTH_PIXELS - GLYPH_W),
                 glyph_origin(HEIGHT_ROWS - GLYPH_H), 6'($urandom_range(HEIGHT_ROWS - 1, 0)));
  endfunction

  task automatic offer(input in_item_t it);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid, wait for every write beat due, then let any silent command finish.
  task automatic go_quiet();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [7:0] row, input logic [7:0] base);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_TEXT_ROW;
    cfg_data_i  <= row;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_ADDR_BASE;
    cfg_data_i  <= base;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
  initial begin
    forever begin
      @(posedge clk_i);
      if (holds_served != holds_asked) begin
        holds_served++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    in_item_t it;
    int       done;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty store, pattern across the row split, glyphs at and past
    // the edges, a glyph straddling two bytes, cursor glyphs, spare codes.
    offer(build(CMD_REFRESH, '0, '0, '0, 6'd0));
    offer(build(CMD_PATTERN, '0, '0, '0, '0));
    offer(build(CMD_REFRESH, '0, '0, '0, 6'd0));
    offer(build(CMD_REFRESH, '0, '0, '0, 6'd63));
    offer(build(CMD_REFRESH, '0, '0, '0, 6'd31));
    offer(build(CMD_REFRESH, '0, '0, '0, 6'd32));
    offer(build(CMD_GLYPH_AT, '1, 8'd0, 8'd0, 6'd0));
    offer(build(CMD_GLYPH_AT, 48'hAA55_AA55_AA55, 8'd122, 8'd56, 6'd63));
    offer(build(CMD_GLYPH_AT, '1, 8'd123, 8'd0, 6'd0));
    offer(build(CMD_GLYPH_AT, '1, 8'd0, 8'd57, 6'd0));
    offer(build(CMD_GLYPH_AT, '1, 8'd255, 8'd255, 6'd0));
    offer(build(CMD_GLYPH_AT, '0, 8'd5, 8'd8, 6'd0));
    offer(build(CMD_GLYPH_CUR, 48'h0F0F_3C3C_F0F0, '0, '0, '0));
    offer(build(CMD_GLYPH_CUR, 48'h8181_4242_2424, '0, '0, '0));
    offer(build(CMD_REFRESH, '0, '0, '0, 6'd1));
    offer(build(CMD_REFRESH, '0, '0, '0, 6'd8));
    offer(build(CMD_REFRESH, '0, '0, '0, 6'd56));
    offer(build(CMD_REFRESH, '0, '0, '0, 6'd63));
    offer(build(CMD_SPARE_HI, '1, '1, '1, '1));
    offer(build(CMD_SPARE_LO, '1, '1, '1, '1));
    offer(build(CMD_CLEAR, '0, '0, '0, '0));
    offer(build(CMD_REFRESH, '0, '0, '0, 6'd0));

    row_by_phase[3]  = 8'($urandom_range(HEIGHT_ROWS - 1, 0));
    base_by_phase[3] = 8'($urandom_range(255, 0));
    row_by_phase[4]  = 8'($urandom_range(255, 0));
    base_by_phase[4] = 8'($urandom_range(255, 0));

    for (int ph = 0; ph < PHASES; ph++) begin
      go_quiet();
      write_regs(row_by_phase[ph], base_by_phase[ph]);
      send_idle_pct = idle_by_phase[ph];
      stall_pct     = stall_by_phase[ph];
      done = 0;
      while (done < RANDOM_ITEMS) begin
        it = random_command();
        offer(it);
        if (it.command <= CMD_REFRESH) done++;
      end
      if (ph == 0) begin
        // Long hold-off on the write side while refreshes keep coming, so
        // the block backs up and stalls its command input.
        holds_asked++;
        repeat (6) offer(build(CMD_REFRESH, '0, '0, '0, 6'($urandom_range(HEIGHT_ROWS - 1, 0))));
      end
      if (ph == 2) begin
        // A line of text long enough for the cursor to wrap, then its rows.
        repeat (TEXT_GLYPHS) offer(build(CMD_GLYPH_CUR, 48'({$urandom, $urandom}),
                                         '0, '0, '0));
        for (int r = 0; r < GLYPH_H; r++) begin
          offer(build(CMD_REFRESH, '0, '0, '0, 6'(row_by_phase[ph] + r)));
        end
      end
    end

    go_quiet();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
